### rtl/soundex_stream_encoder_macros.svh
// Assertion helpers; every user has aclk and aresetn in scope.
`ifndef SOUNDEX_STREAM_ENCODER_MACROS_SVH
`define SOUNDEX_STREAM_ENCODER_MACROS_SVH

// Same-cycle implication, off during reset.
`define SNDX_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("soundex encoder check failed");

// Next-cycle implication, off during reset.
`define SNDX_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("soundex encoder check failed");

`endif

### rtl/sndx_pkg.sv
`default_nettype none
package sndx_pkg;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_SIX   = 8'h36;
    localparam logic [7:0] CHAR_LOW_A = 8'h61;
    localparam logic [7:0] CHAR_LOW_Z = 8'h7a;
    localparam logic [7:0] CASE_BIT   = 8'h20;
    localparam logic [2:0] CODE_NONE  = 3'd0;
    localparam logic [1:0] MAX_DIGITS = 2'd3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } sndx_in_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       final_char;
        logic       no_letters;
    } sndx_out_t;

    // One queued job: up to two letters/digits, then zero padding.
    typedef struct packed {
        logic [7:0] char0;
        logic [7:0] char1;
        logic [1:0] n_chars;
        logic [1:0] n_pad;
        logic       is_end;
        logic       none;
    } sndx_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } sndx_qstat_t;

    // Soundex group of a letter; pos is 1 for a through 26 for z.
    function automatic logic [2:0] letter_code(input logic [4:0] pos);
        logic [2:0] c;
        unique case (pos)
            5'd2, 5'd6, 5'd16, 5'd22:                       c = 3'd1;
            5'd3, 5'd7, 5'd10, 5'd11, 5'd17, 5'd19, 5'd24,
            5'd26:                                          c = 3'd2;
            5'd4, 5'd20:                                    c = 3'd3;
            5'd12:                                          c = 3'd4;
            5'd13, 5'd14:                                   c = 3'd5;
            5'd18:                                          c = 3'd6;
            default:                                        c = CODE_NONE;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

### rtl/sndx_front.sv
`default_nettype none
module sndx_front import sndx_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      accept,
    input  wire sndx_in_t  in_item,
    output logic           push,
    output sndx_job_t      job
);

    logic       letter_seen_reg, letter_seen_next;
    logic [2:0] prev_code_reg, prev_code_next;
    logic [1:0] digits_reg, digits_next;
    logic       held_valid_reg, held_valid_next;
    logic [7:0] held_char_reg, held_char_next;

    logic [7:0] lower;
    logic       is_letter;
    logic [2:0] code;
    logic       have_new;
    logic [7:0] new_char;
    logic [1:0] n_chars;
    logic [1:0] rem_d;
    logic [2:0] rem_n;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            letter_seen_reg <= 1'b0;
            prev_code_reg   <= CODE_NONE;
            digits_reg      <= 2'd0;
            held_valid_reg  <= 1'b0;
        end else if (accept) begin
            letter_seen_reg <= letter_seen_next;
            prev_code_reg   <= prev_code_next;
            digits_reg      <= digits_next;
            held_valid_reg  <= held_valid_next;
        end
        if (accept) begin
            held_char_reg <= held_char_next;
        end
    end

    always_comb begin
        lower     = in_item.in_byte | CASE_BIT;
        is_letter = (lower >= CHAR_LOW_A) && (lower <= CHAR_LOW_Z);
        code      = is_letter ? letter_code(lower[4:0]) : CODE_NONE;

        letter_seen_next = letter_seen_reg;
        prev_code_next   = prev_code_reg;
        digits_next      = digits_reg;
        held_valid_next  = held_valid_reg;
        held_char_next   = held_char_reg;
        have_new         = 1'b0;
        new_char         = 8'd0;

        if (is_letter) begin
            if (!letter_seen_reg) begin
                letter_seen_next = 1'b1;
                prev_code_next   = code;
                new_char         = lower & ~CASE_BIT;
                have_new         = 1'b1;
            end else if (code != CODE_NONE) begin
                if (code != prev_code_reg) begin
                    new_char = CHAR_ZERO | {5'd0, code};
                    have_new = 1'b1;
                    if (digits_reg < MAX_DIGITS) begin
                        digits_next = digits_reg + 2'd1;
                    end
                end
                prev_code_next = code;
            end
        end

        push         = 1'b0;
        job          = '0;
        n_chars      = {1'b0, held_valid_reg} + {1'b0, have_new};
        rem_d        = MAX_DIGITS - digits_next;
        rem_n        = 3'd4 - {1'b0, n_chars};

        if (!in_item.end_of_string) begin
            // Release the held character once a newer one replaces it.
            if (have_new) begin
                push            = held_valid_reg;
                job.char0       = held_char_reg;
                job.n_chars     = 2'd1;
                held_valid_next = 1'b1;
                held_char_next  = new_char;
            end
        end else begin
            push = 1'b1;
            job.is_end = 1'b1;
            if (!letter_seen_next) begin
                job.n_chars = 2'd1;
                job.none    = 1'b1;
            end else begin
                job.char0   = held_valid_reg ? held_char_reg : new_char;
                job.char1   = new_char;
                job.n_chars = n_chars;
                job.n_pad   = ({1'b0, rem_d} <= rem_n) ? rem_d : rem_n[1:0];
            end
            letter_seen_next = 1'b0;
            prev_code_next   = CODE_NONE;
            digits_next      = 2'd0;
            held_valid_next  = 1'b0;
            held_char_next   = 8'd0;
        end
    end

endmodule
`default_nettype wire

### rtl/sndx_queue.sv
`default_nettype none
module sndx_queue import sndx_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  wire sndx_job_t wr_job,
    input  wire logic      pop,
    output sndx_job_t      rd_job,
    output sndx_qstat_t    stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    sndx_job_t     slots_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    always_comb begin
        stat.full   = (count_reg == FULL_CNT);
        stat.empty  = (count_reg == '0);
        do_push     = push && !stat.full;
        do_pop      = pop && !stat.empty;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        count_next = count_reg + CW'(do_push) - CW'(do_pop);
        rd_job     = slots_reg[rd_ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule
`default_nettype wire

### rtl/sndx_back.sv
`default_nettype none
module sndx_back import sndx_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire sndx_job_t   job,
    input  wire sndx_qstat_t stat,
    output logic             pop,
    output logic             m_valid,
    input  wire logic        m_ready,
    output sndx_out_t        m_data
);

    logic       valid_reg, valid_next;
    sndx_out_t  data_reg, data_next;
    logic [1:0] idx_reg, idx_next;
    logic [2:0] total;
    logic       last;
    logic       load;

    always_comb begin
        total      = {1'b0, job.n_chars} + {1'b0, job.n_pad};
        last       = ({1'b0, idx_reg} == total - 3'd1);
        load       = !valid_reg || m_ready;
        valid_next = valid_reg;
        data_next  = data_reg;
        idx_next   = idx_reg;
        pop        = 1'b0;
        if (load) begin
            valid_next = !stat.empty;
            if (idx_reg < job.n_chars) begin
                data_next.out_char = (idx_reg == 2'd0) ? job.char0 : job.char1;
            end else begin
                data_next.out_char = CHAR_ZERO;
            end
            data_next.final_char = job.is_end && last;
            data_next.no_letters = job.none;
            if (!stat.empty) begin
                // Advance through the job; drop it after its last character.
                pop      = last;
                idx_next = last ? 2'd0 : idx_reg + 2'd1;
            end
        end
        m_valid = valid_reg;
        m_data  = data_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
        data_reg <= data_next;
    end

endmodule
`default_nettype wire

### rtl/soundex_stream_encoder.sv
`default_nettype none
// Soundex encoder over a byte stream: one ASCII byte per input transfer, end_of_string on
// the last byte of each string. Results are the code characters (upper-case first letter,
// then digits '0'..'6', never truncated, zero-padded to three digits), the last one flagged
// by final_char; a string with no letters yields one result with no_letters set. The input
// takes one byte per cycle while the queue is not full. A byte produces at most one result;
// a string's final byte produces up to four, which the output stage issues one per cycle
// while the output does not stall. A queue of QUEUE_DEPTH jobs sits between the byte
// classifier and the output stage; the job being issued stays at the head of the queue, so
// while padding drains or the output stalls the input takes bytes that make no job, plus up
// to QUEUE_DEPTH - 1 further jobs, and then waits.
`include "soundex_stream_encoder_macros.svh"
module soundex_stream_encoder import sndx_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire sndx_in_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output sndx_out_t      m_data
);

    logic        accept;
    logic        q_push;
    logic        q_pop;
    sndx_job_t   q_wr_job;
    sndx_job_t   q_rd_job;
    sndx_qstat_t q_stat;
    logic        code_end;
    logic        is_digit;

    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;

    sndx_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .in_item (s_data),
        .push    (q_push),
        .job     (q_wr_job)
    );

    sndx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push && accept),
        .wr_job  (q_wr_job),
        .pop     (q_pop),
        .rd_job  (q_rd_job),
        .stat    (q_stat)
    );

    sndx_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .job     (q_rd_job),
        .stat    (q_stat),
        .pop     (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    assign code_end = m_valid && m_data.final_char && !m_data.no_letters;
    assign is_digit = (m_data.out_char >= CHAR_ZERO) && (m_data.out_char <= CHAR_SIX);

    `SNDX_ASSERT_IMPLY(a_none_is_final, m_valid && m_data.no_letters, m_data.final_char)
    `SNDX_ASSERT_IMPLY(a_final_is_digit, code_end, is_digit)
    `SNDX_ASSERT_IMPLY(a_pop_has_data, q_pop, !q_stat.empty)
    `SNDX_ASSERT_NEXT(a_stall_holds, m_valid && !m_ready, m_valid)

endmodule
`default_nettype wire

### dv/soundex_stream_encoder_test.sv
`default_nettype none
module soundex_stream_encoder_test;
    import sndx_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT   = 2000;
    localparam int TAIL_CYCLES  = 20;
    localparam int RANDOM_BYTES = 260;
    localparam int NOISE_BYTES  = 60;
    localparam int BURST_BYTES  = 50;
    localparam int HOLD_BYTES   = 40;
    localparam int HOLD_CYCLES  = 250;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    sndx_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    sndx_out_t m_data;

    // Encoder image: mirrors the block's string state.
    logic       word_started;
    logic [2:0] last_group;
    logic [1:0] digit_count;
    logic       pending_valid;
    logic [7:0] pending_char;
    sndx_out_t  expected_chars[$];

    int mismatches = 0;
    int bytes_sent = 0;
    int idle_cycles = 0;
    int rx_hold_req = 0;
    int rx_stall_left = 0;
    bit tx_burst = 1'b0;
    bit rx_burst = 1'b0;

    soundex_stream_encoder i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5ns aclk = 1'b1;
        #5ns aclk = 1'b0;
    end

    function automatic logic [2:0] group_of(input logic [7:0] lc);
        case (lc)
            "b", "f", "p", "v":                          return 3'd1;
            "c", "g", "j", "k", "q", "s", "x", "z":      return 3'd2;
            "d", "t":                                    return 3'd3;
            "l":                                         return 3'd4;
            "m", "n":                                    return 3'd5;
            "r":                                         return 3'd6;
            default:                                     return CODE_NONE;
        endcase
    endfunction

    function automatic void clear_encoder();
        word_started  = 1'b0;
        last_group    = CODE_NONE;
        digit_count   = '0;
        pending_valid = 1'b0;
        pending_char  = '0;
    endfunction

    function automatic void encode_byte(input sndx_in_t item);
        logic [7:0] lc;
        logic [2:0] grp;
        logic       fresh;
        logic [7:0] fresh_char;
        logic [7:0] code_tail[$];
        lc = item.in_byte | CASE_BIT;
        fresh = 1'b0;
        fresh_char = '0;
        if (lc >= CHAR_LOW_A && lc <= CHAR_LOW_Z) begin
            grp = group_of(lc);
            if (!word_started) begin
                word_started = 1'b1;
                last_group = grp;
                fresh = 1'b1;
                fresh_char = lc & ~CASE_BIT;
            end else if (grp != CODE_NONE) begin
                if (grp != last_group) begin
                    fresh = 1'b1;
                    fresh_char = CHAR_ZERO + {5'd0, grp};
                    if (digit_count < MAX_DIGITS) digit_count++;
                end
                last_group = grp;
            end
        end
        if (!item.end_of_string) begin
            // Release the held character only when a newer one replaces it.
            if (fresh) begin
                if (pending_valid) expected_chars.push_back({pending_char, 1'b0, 1'b0});
                pending_valid = 1'b1;
                pending_char = fresh_char;
            end
        end else begin
            if (!word_started) begin
                expected_chars.push_back({8'h00, 1'b1, 1'b1});
            end else begin
                if (pending_valid) code_tail.push_back(pending_char);
                if (fresh) code_tail.push_back(fresh_char);
                while (digit_count < MAX_DIGITS && code_tail.size() < 4) begin
                    code_tail.push_back(CHAR_ZERO);
                    digit_count++;
                end
                foreach (code_tail[i])
                    expected_chars.push_back({code_tail[i], i == code_tail.size() - 1, 1'b0});
            end
            clear_encoder();
        end
    endfunction

    function automatic void check_result(input sndx_out_t got);
        sndx_out_t want;
        if (expected_chars.size() == 0) begin
            $error("unexpected result: out_char %h final_char %b no_letters %b",
                   got.out_char, got.final_char, got.no_letters);
            mismatches++;
        end else begin
            want = expected_chars.pop_front();
            // out_char carries nothing on a no-letters result
            if (!want.no_letters && got.out_char !== want.out_char) begin
                $error("out_char: expected %h, actual %h", want.out_char, got.out_char);
                mismatches++;
            end
            if (got.final_char !== want.final_char) begin
                $error("final_char: expected %b, actual %b", want.final_char, got.final_char);
                mismatches++;
            end
            if (got.no_letters !== want.no_letters) begin
                $error("no_letters: expected %b, actual %b", want.no_letters, got.no_letters);
                mismatches++;
            end
        end
    endfunction

    // Mostly zero, some short, a few long.
    function automatic int idle_length(input int zero_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < zero_pct) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) encode_byte(s_data);
            if (m_valid && m_ready) check_result(m_data);
        end
    end

    always @(posedge aclk) begin
        int stall;
        if (rx_hold_req > 0) begin
            rx_stall_left = rx_hold_req - 1;
            rx_hold_req = 0;
            m_ready <= 1'b0;
        end else if (rx_stall_left > 0) begin
            rx_stall_left--;
            m_ready <= 1'b0;
        end else if (rx_burst) begin
            m_ready <= 1'b1;
        end else begin
            stall = idle_length(75);
            if (stall > 0) begin
                rx_stall_left = stall - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[soundex_stream_encoder] ERROR");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eos);
        int gap;
        gap = tx_burst ? 0 : idle_length(60);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= {b, eos};
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    task automatic send_string(input string text);
        for (int i = 0; i < text.len(); i++)
            send_byte(text[i], i == text.len() - 1);
    endtask

    function automatic logic [7:0] random_non_letter();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (((b | CASE_BIT) >= CHAR_LOW_A) && ((b | CASE_BIT) <= CHAR_LOW_Z));
        return b;
    endfunction

    // One string: mostly letters in random case, repeats to hit suppression.
    task automatic send_word();
        int len;
        logic [7:0] b;
        logic [7:0] prev;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 8);
        prev = "a";
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < 12) begin
                b = random_non_letter();
            end else begin
                if ($urandom_range(0, 4) == 0) b = prev;
                else b = 8'($urandom_range(CHAR_LOW_A, CHAR_LOW_Z));
                prev = b;
                if ($urandom_range(0, 1)) b = b & ~CASE_BIT;
            end
            send_byte(b, i == len - 1);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        // let the monitor take the last transfer before looking at the queue
        @(posedge aclk);
        while (expected_chars.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic test_reference_words();
        send_string("Bp");
        send_string("Ashc");
        send_string("zZ");
        // no letters at all, bytes around the letter ranges
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h40, 1'b0);
        send_byte(8'h5b, 1'b0);
        send_byte(8'h60, 1'b0);
        send_byte(8'h7b, 1'b1);
        send_string("Ob");
        send_string("Rdlmr9");
        send_string("j");
        drain_results();
    endtask

    task automatic test_noise_bytes();
        for (int i = 0; i < NOISE_BYTES; i++)
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        drain_results();
    endtask

    task automatic test_random_words();
        int target;
        target = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < target) send_word();
        drain_results();
    endtask

    task automatic test_output_backpressure();
        int target;
        target = bytes_sent + HOLD_BYTES;
        tx_burst = 1'b1;
        rx_hold_req = HOLD_CYCLES;
        while (bytes_sent < target) send_word();
        tx_burst = 1'b0;
        drain_results();
    endtask

    task automatic test_back_to_back();
        int target;
        target = bytes_sent + BURST_BYTES;
        tx_burst = 1'b1;
        rx_burst = 1'b1;
        while (bytes_sent < target) send_word();
        tx_burst = 1'b0;
        rx_burst = 1'b0;
        drain_results();
    endtask

    initial begin
        clear_encoder();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reference_words();
        test_noise_bytes();
        test_random_words();
        test_output_backpressure();
        test_back_to_back();
        if (mismatches == 0) begin
            $display("[soundex_stream_encoder] OK");
        end else begin
            $display("[soundex_stream_encoder] ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire
